@@ rtl/rdc_pkg.sv @@
// ---------------------------------------------------------------------------
// rdc_pkg: shared definitions for the radix digit converter
// Widths, radix limits, controller states, the link between digit cells and
// the digit to ASCII mapping.
// ---------------------------------------------------------------------------
package rdc_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int RADIX_W        = 5;
  localparam int DIGIT_W        = 4;
  localparam int CHAR_W         = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } rdc_state_t;

  // Carry handed from one digit cell to the next, with its step strobe
  typedef struct packed {
    logic active;
    logic carry;
  } rdc_link_t;

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage

@@ rtl/rdc_channels.sv @@
// ---------------------------------------------------------------------------
// rdc_channels: valid/ready channels of the radix digit converter
// Input value channel, digit output channel and radix write channel.
// ---------------------------------------------------------------------------
interface rdc_value_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rdc_digit_if;
  logic       valid;
  logic       ready;
  logic [6:0] digit_char;
  logic       last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

interface rdc_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] radix;

  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

@@ rtl/radix_digit_converter.sv @@
// ---------------------------------------------------------------------------
// radix_digit_converter: signed integer to base-N ASCII digit string
// Conversion runs through the digit cell chain: one magnitude bit enters per
// cycle and carries ripple one cell per cycle. Leading zeros are then skipped
// and digit words are sent, stalling while the receiver is not ready. A new
// value is taken only in idle, after every digit word of the last one is issued.
// Reset: synchronous, radix returns to 10, controller to idle, no word held.
// ---------------------------------------------------------------------------
module radix_digit_converter
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  rdc_value_if.sink      number,
  rdc_cfg_if.sink        cfg,
  rdc_digit_if.source    digit
);

  localparam int MAG_W = VALUE_BITS - 1;
  localparam int NC    = VALUE_BITS - 1;
  localparam int CNT_W = $clog2(2 * VALUE_BITS);
  localparam int REM_W = $clog2(VALUE_BITS);
  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(MAG_W + NC - 2);
  localparam logic [CNT_W-1:0] FEED_LEN  = CNT_W'(MAG_W);
  localparam logic [REM_W-1:0] REM_FULL  = REM_W'(NC);
  localparam logic [REM_W-1:0] REM_ONE   = REM_W'(1);

  rdc_state_t         state;
  rdc_state_t         state_next;
  logic [RADIX_W-1:0] radix;
  logic [RADIX_W-1:0] radix_eff;
  logic [MAG_W-1:0]   mag;
  logic [CNT_W-1:0]   cnt;
  logic [REM_W-1:0]   remain;
  logic               started;
  logic               out_valid;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;

  logic               accept;
  logic               in_ready;
  logic               slot_free;
  logic               skip;
  logic               emit;
  logic               chain_shift;
  rdc_link_t          head_link;
  rdc_link_t          link [NC];
  logic [DIGIT_W-1:0] digits [NC];
  logic [DIGIT_W-1:0] top_digit;

  // Radix register and its clamp to 2..16
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg.valid && cfg.ready) begin
      radix <= cfg.radix;
    end
  end

  always_comb begin
    if (radix < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix;
    end
  end

  assign number.ready = in_ready;
  assign accept       = number.valid && in_ready;
  assign top_digit    = digits[NC-1];
  assign slot_free    = !out_valid || digit.ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (cnt == CONV_LAST) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit && remain == REM_ONE) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_ready         = 1'b0;
    head_link.active = 1'b0;
    head_link.carry  = 1'b0;
    skip             = 1'b0;
    emit             = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_CONV: begin
        head_link.active = (cnt < FEED_LEN);
        head_link.carry  = (cnt < FEED_LEN) && mag[MAG_W-1];
      end
      ST_EMIT: begin
        skip = (remain > REM_ONE) && (top_digit == '0) && !started;
        emit = !skip && slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign chain_shift = skip || emit;

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      remain  <= '0;
      started <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt     <= '0;
        remain  <= REM_FULL;
        started <= 1'b0;
      end else begin
        if (state == ST_CONV) begin
          cnt <= cnt + 1'b1;
        end
        if (chain_shift) begin
          remain <= remain - 1'b1;
        end
        if (emit) begin
          started <= 1'b1;
        end
      end
    end
  end

  // Load the magnitude, drop it for negatives, feed it MSB first
  always_ff @(posedge clk) begin
    if (accept) begin
      mag <= number.value[VALUE_BITS-1] ? '0 : number.value[MAG_W-1:0];
    end else if (state == ST_CONV) begin
      mag <= {mag[MAG_W-2:0], 1'b0};
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (digit.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= digit_ascii(top_digit);
      out_last <= (remain == REM_ONE);
    end
  end

  assign digit.valid      = out_valid;
  assign digit.digit_char = out_char;
  assign digit.last_digit = out_last;

  // Digit cell chain, least significant cell first
  for (genvar i = 0; i < NC; i++) begin : g_cell
    if (i == 0) begin : g_head
      rdc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .clear    (accept),
        .shift    (chain_shift),
        .radix    (radix_eff),
        .link_in  (head_link),
        .digit_in ({DIGIT_W{1'b0}}),
        .link_out (link[i]),
        .digit    (digits[i])
      );
    end else begin : g_body
      rdc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .clear    (accept),
        .shift    (chain_shift),
        .radix    (radix_eff),
        .link_in  (link[i-1]),
        .digit_in (digits[i-1]),
        .link_out (link[i]),
        .digit    (digits[i])
      );
    end
  end

endmodule

@@ rtl/rdc_cell.sv @@
// ---------------------------------------------------------------------------
// rdc_cell: one digit cell of the conversion chain
// Holds one digit in the current radix. On each step it doubles its digit,
// adds the carry from the lower cell and passes its own carry up in the cycle
// after. In emit mode the chain shifts digits toward the top cell.
// ---------------------------------------------------------------------------
module rdc_cell
  import rdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               shift,
  input  logic [RADIX_W-1:0] radix,
  input  rdc_link_t          link_in,
  input  logic [DIGIT_W-1:0] digit_in,
  output rdc_link_t          link_out,
  output logic [DIGIT_W-1:0] digit
);

  logic [RADIX_W-1:0] dbl;
  logic [RADIX_W-1:0] dbl_sub;
  logic               over;

  // Double and fold back into range
  always_comb begin
    dbl     = {digit, link_in.carry};
    over    = (dbl >= radix);
    dbl_sub = dbl - radix;
  end

  // Hold the digit and the registered link to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out <= '0;
    end else if (clear) begin
      link_out <= '0;
      digit    <= '0;
    end else if (shift) begin
      link_out <= '0;
      digit    <= digit_in;
    end else begin
      link_out.active <= link_in.active;
      link_out.carry  <= link_in.active & over;
      if (link_in.active) begin
        digit <= over ? dbl_sub[DIGIT_W-1:0] : dbl[DIGIT_W-1:0];
      end
    end
  end

endmodule

@@ bench/rdc_digit_checker.sv @@
// ---------------------------------------------------------------------------
// rdc_digit_checker: digit stream scoreboard for the radix digit converter
// Watches the radix write, value and digit channels. Every accepted value is
// spelled out in the current radix into a list of expected digit words. Every
// accepted digit word is compared with the oldest one waiting.
// ---------------------------------------------------------------------------
module rdc_digit_checker
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         number_valid,
  input  logic                         number_ready,
  input  logic signed [VALUE_BITS-1:0] number_value,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [RADIX_W-1:0]           cfg_radix,
  input  logic                         digit_valid,
  input  logic                         digit_ready,
  input  logic [CHAR_W-1:0]            digit_char,
  input  logic                         digit_last,
  output int                           errors,
  output int                           pending
);

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } digit_word_t;

  digit_word_t        pending_digits[$];
  digit_word_t        head;
  logic [RADIX_W-1:0] radix_q;
  int                 fail_count = 0;
  int                 queued     = 0;

  assign errors  = fail_count;
  assign pending = queued;

  // Clamp the radix register to the supported bases
  function automatic logic [63:0] active_base(input logic [RADIX_W-1:0] r);
    logic [63:0] b;
    if (r < RADIX_MIN) begin
      b = 64'(RADIX_MIN);
    end else if (r > RADIX_MAX) begin
      b = 64'(RADIX_MAX);
    end else begin
      b = 64'(r);
    end
    return b;
  endfunction

  // Spell one value in the given radix, most significant digit first
  task automatic spell_value(input logic [VALUE_BITS-1:0] v,
                             input logic [RADIX_W-1:0] r);
    logic [63:0] base;
    logic [63:0] rest;
    logic [63:0] power;
    logic [63:0] d;
    digit_word_t w;
    base = active_base(r);
    // Negative values collapse to a lone zero digit
    if (v[VALUE_BITS-1]) begin
      w.char_code = CHAR_ZERO;
      w.last      = 1'b1;
      pending_digits.push_back(w);
      return;
    end
    rest  = 64'(v);
    power = 64'd1;
    while (power <= rest / base) power = power * base;
    while (power != 64'd0) begin
      d     = rest / power;
      rest  = rest - d * power;
      power = power / base;
      if (d < 64'(DIGIT_TEN)) begin
        w.char_code = CHAR_ZERO + CHAR_W'(d);
      end else begin
        w.char_code = CHAR_A + CHAR_W'(d - 64'(DIGIT_TEN));
      end
      w.last = (power == 64'd0);
      pending_digits.push_back(w);
    end
  endtask

  // Track the radix, check digit words, then queue digits of new values
  always @(posedge clk) begin
    if (rst) begin
      radix_q <= RADIX_RESET;
      pending_digits.delete();
    end else begin
      if (digit_valid && digit_ready) begin
        if (pending_digits.size() == 0) begin
          fail_count++;
          $error("digit word with none expected: digit_char %0d last_digit %0b",
                 digit_char, digit_last);
        end else begin
          head = pending_digits.pop_front();
          if (digit_char !== head.char_code) begin
            fail_count++;
            $error("digit_char mismatch: expected %0d, actual %0d",
                   head.char_code, digit_char);
          end
          if (digit_last !== head.last) begin
            fail_count++;
            $error("last_digit mismatch: expected %0b, actual %0b",
                   head.last, digit_last);
          end
        end
      end
      if (number_valid && number_ready) begin
        spell_value(number_value, radix_q);
      end
      if (cfg_valid && cfg_ready) begin
        radix_q <= cfg_radix;
      end
    end
    queued = pending_digits.size();
  end

endmodule

@@ bench/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench: top level for the radix digit converter
// Drives values and radix writes, a digit receiver with random and long
// stalls, and a run timeout. Checking lives in rdc_digit_checker; this module
// gives the verdict from its error count.
// ---------------------------------------------------------------------------
module testbench;
  import rdc_pkg::*;

  localparam int VALUE_BITS  = VALUE_BITS_DEF;
  localparam int PHASE_ITEMS = 52;
  localparam int HOLD_CYCLES = 700;
  localparam int DRAIN_WAIT  = 3 * VALUE_BITS + 16;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic hold_off;
  logic stall_go;
  int   send_gap_pct;
  int   recv_gap_pct;
  int   errors;
  int   pending;
  int   cycle_count;

  rdc_value_if #(.VALUE_BITS(VALUE_BITS)) number_ch ();
  rdc_cfg_if                              cfg_ch ();
  rdc_digit_if                            digit_ch ();

  radix_digit_converter #(
    .VALUE_BITS(VALUE_BITS)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .number(number_ch),
    .cfg   (cfg_ch),
    .digit (digit_ch)
  );

  rdc_digit_checker #(
    .VALUE_BITS(VALUE_BITS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .number_valid(number_ch.valid),
    .number_ready(number_ch.ready),
    .number_value(number_ch.value),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_radix   (cfg_ch.radix),
    .digit_valid (digit_ch.valid),
    .digit_ready (digit_ch.ready),
    .digit_char  (digit_ch.digit_char),
    .digit_last  (digit_ch.last_digit),
    .errors      (errors),
    .pending     (pending)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Digit receiver: random stalls, forced low during a hold-off
  initial begin
    digit_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      digit_ch.ready <= !hold_off && ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input
  initial begin
    hold_off = 1'b0;
    wait (stall_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  // Offer one value word, idling at random first; returns at a falling edge
  task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
    while ($urandom_range(99) < send_gap_pct) begin
      number_ch.valid <= 1'b0;
      @(negedge clk);
    end
    number_ch.valid <= 1'b1;
    number_ch.value <= v;
    @(posedge clk);
    while (!number_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold until every expected digit word has come out
  task automatic wait_drained();
    number_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Write the radix register; returns at a falling edge
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    cfg_ch.valid <= 1'b1;
    cfg_ch.radix <= r;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Draw a value: negatives, small ones, random widths, near radix powers
  function automatic logic [VALUE_BITS-1:0] pick_value(input int base);
    logic [VALUE_BITS-1:0] v;
    longint                p;
    int                    sel;
    int                    k;
    sel = $urandom_range(99);
    if (sel < 15) begin
      v = $urandom | 32'h8000_0000;
    end else if (sel < 25) begin
      v = $urandom_range(0, base * base);
    end else if (sel < 55) begin
      k = $urandom_range(1, 31);
      v = $urandom & ((32'h1 << k) - 1);
    end else if (sel < 80) begin
      p = 1;
      repeat ($urandom_range(0, 30)) begin
        if (p * base <= 64'h7FFF_FFFF) p = p * base;
      end
      v = VALUE_BITS'(p + $urandom_range(0, 2) - 1);
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Stimulus and verdict
  initial begin
    logic [RADIX_W-1:0] radix_plan [6];
    int                 base;
    rst             = 1'b1;
    stall_go        = 1'b0;
    send_gap_pct    = 0;
    recv_gap_pct    = 0;
    number_ch.valid = 1'b0;
    number_ch.value = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.radix    = RADIX_RESET;
    radix_plan      = '{5'd3, RADIX_MAX, RADIX_MIN, 5'd7, RADIX_RESET, 5'd0};
    radix_plan[5]   = RADIX_W'($urandom_range(0, 31));

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset radix, zero, negatives, extremes, digit rollovers
    send_value(0);
    send_value(1);
    send_value(-1);
    send_value(32'sh8000_0000);
    send_value(32'sh7FFF_FFFF);
    send_value(9);
    send_value(10);
    send_value(99);
    send_value(100);
    wait_drained();
    // Base two: longest digit run
    write_radix(RADIX_MIN);
    send_value(32'sh7FFF_FFFF);
    send_value(1);
    send_value(2);
    send_value(3);
    wait_drained();
    // Base sixteen: letter digits
    write_radix(RADIX_MAX);
    send_value(32'sh7FFF_FFFF);
    send_value(255);
    send_value(256);
    send_value(32'sh0FED_CBA9);
    wait_drained();
    // Out-of-range radix saturates to the nearest supported base
    write_radix(5'd0);
    send_value(5);
    wait_drained();
    write_radix(5'd31);
    send_value(32'sh000A_BCDE);
    wait_drained();
    write_radix(5'd1);
    send_value(4);
    wait_drained();
    write_radix(5'd17);
    send_value(16);
    wait_drained();

    // Random phases: new radix each, idling pattern changes every two
    for (int ph = 0; ph < 6; ph++) begin
      write_radix(radix_plan[ph]);
      if (ph < 2) begin
        send_gap_pct = 32;
        recv_gap_pct = 54;
      end else if (ph < 4) begin
        send_gap_pct = 54;
        recv_gap_pct = 32;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      if (ph == 2) stall_go = 1'b1;
      base = radix_plan[ph] < RADIX_MIN ? int'(RADIX_MIN) :
             radix_plan[ph] > RADIX_MAX ? int'(RADIX_MAX) : int'(radix_plan[ph]);
      repeat (PHASE_ITEMS) send_value(pick_value(base));
      wait_drained();
    end

    // Let any stray words show up before the verdict
    repeat (DRAIN_WAIT) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
